// ===== rtl/crc8hx_pkg.sv =====
package crc8hx_pkg;

	typedef enum logic [1:0] {
		KIND_ECHO    = 2'd0,
		KIND_HEX     = 2'd1,
		KIND_VERDICT = 2'd2
	} kind_t;

	localparam logic [0:0] MODE_GEN   = 1'b0;
	localparam logic [0:0] MODE_CHECK = 1'b1;

	localparam logic [7:0] CRC_POLY      = 8'h8C;
	localparam logic [7:0] NIB_LO_MASK   = 8'b0000_1111;
	localparam logic [7:0] NIB_HI_MASK   = 8'b1111_0000;
	localparam logic [7:0] ASCII_ZERO    = 8'd48;
	localparam logic [7:0] ASCII_NINE    = 8'd57;
	localparam logic [7:0] ASCII_A_OFS   = 8'd55;
	localparam logic [7:0] ASCII_UPPER_A = 8'd65;
	localparam logic [7:0] ASCII_UPPER_F = 8'd70;

	localparam logic [1:0] SEEN_FULL = 2'd2;

	// One beat's worth of work handed to the result stage.
	typedef struct packed {
		logic       check;
		logic       last;
		logic       ok;
		logic [7:0] ch;
		logic [7:0] crc;
	} rec_t;

	// Reflected CRC-8, poly 0x8C, one byte.
	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		for (int b = 0; b < 8; b++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	function automatic logic [7:0] nibble_to_hex(input logic [3:0] n);
		logic [7:0] w;
		w = {4'd0, n};
		return (w <= 8'd9) ? (w + ASCII_ZERO) : (w + ASCII_A_OFS);
	endfunction

	// Anything outside '0'-'9' and 'A'-'F' decodes as zero.
	function automatic logic [3:0] hex_to_nibble(input logic [7:0] ch);
		logic [7:0] d;
		d = 8'd0;
		if (ch >= ASCII_ZERO && ch <= ASCII_NINE) begin
			d = ch - ASCII_ZERO;
		end else if (ch >= ASCII_UPPER_A && ch <= ASCII_UPPER_F) begin
			d = ch - ASCII_A_OFS;
		end
		return d[3:0];
	endfunction

endpackage

// ===== rtl/crc8hx_if.sv =====
interface crc8hx_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;
	logic       last_char;

	modport source (output valid, output char_in, output last_char, input ready);
	modport sink (input valid, input char_in, input last_char, output ready);
endinterface

interface crc8hx_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] char_out;
	logic       crc_ok;
	logic       last_out;

	modport source (output valid, output kind, output char_out, output crc_ok,
		output last_out, input ready);
	modport sink (input valid, input kind, input char_out, input crc_ok,
		input last_out, output ready);
endinterface

// ===== rtl/crc8hx_msg.sv =====
module crc8hx_msg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_wdata,
	input  logic               accept,
	input  logic [7:0]         char_in,
	input  logic               last_char,
	output crc8hx_pkg::rec_t   rec,
	output logic               rec_load
);

	logic       mode_q;
	logic [7:0] crc_q;
	logic [7:0] older_q;
	logic [7:0] newer_q;
	logic [1:0] seen_q;

	logic [7:0] crc_gen;
	logic [7:0] crc_chk;
	logic [7:0] stored;
	logic       is_check;

	assign is_check = (mode_q == crc8hx_pkg::MODE_CHECK);
	assign crc_gen  = crc8hx_pkg::crc8_update(crc_q, char_in);
	// oldest held byte only enters the CRC once two newer ones sit behind it
	assign crc_chk  = (seen_q >= crc8hx_pkg::SEEN_FULL) ?
		crc8hx_pkg::crc8_update(crc_q, older_q) : crc_q;
	assign stored   = {crc8hx_pkg::hex_to_nibble(newer_q), crc8hx_pkg::hex_to_nibble(char_in)};

	always_comb begin
		rec.check = is_check;
		rec.last  = last_char;
		rec.ch    = char_in;
		rec.crc   = is_check ? crc_chk : crc_gen;
		rec.ok    = is_check && (seen_q != 2'd0) && (stored == crc_chk);
		rec_load  = accept && (!is_check || last_char);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= crc8hx_pkg::MODE_GEN;
			crc_q   <= 8'd0;
			older_q <= 8'd0;
			newer_q <= 8'd0;
			seen_q  <= 2'd0;
		end else if (cfg_we) begin
			mode_q  <= cfg_wdata;
			crc_q   <= 8'd0;
			older_q <= 8'd0;
			newer_q <= 8'd0;
			seen_q  <= 2'd0;
		end else if (accept) begin
			if (last_char) begin
				crc_q   <= 8'd0;
				older_q <= 8'd0;
				newer_q <= 8'd0;
				seen_q  <= 2'd0;
			end else if (!is_check) begin
				crc_q <= crc_gen;
			end else begin
				crc_q   <= crc_chk;
				older_q <= newer_q;
				newer_q <= char_in;
				if (seen_q < crc8hx_pkg::SEEN_FULL) begin
					seen_q <= seen_q + 2'd1;
				end
			end
		end
	end

	a_seen_sat: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q != 2'd3)
		else $error("held count past two");

	a_gen_no_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!is_check |-> (seen_q == 2'd0))
		else $error("bytes held in generate mode");

endmodule

// ===== rtl/crc8hx_out.sv =====
module crc8hx_out (
	input  logic             clk,
	input  logic             arst_n,
	input  crc8hx_pkg::rec_t rec_i,
	input  logic             rec_load,
	output logic             slot_free,
	crc8hx_out_if.source     tx
);

	crc8hx_pkg::rec_t rec_s1;
	logic             vld_s1;
	logic [1:0]       idx_q;
	logic             beat_last;
	crc8hx_pkg::kind_t kind;

	// generate-mode last char spreads over echo, high hex, low hex
	assign beat_last = rec_s1.check || !rec_s1.last || (idx_q == 2'd2);
	assign slot_free = !vld_s1 || (tx.ready && beat_last);

	always_comb begin
		kind = crc8hx_pkg::KIND_ECHO;
		tx.char_out = rec_s1.ch;
		tx.crc_ok   = 1'b0;
		tx.last_out = 1'b0;
		if (rec_s1.check) begin
			kind        = crc8hx_pkg::KIND_VERDICT;
			tx.char_out = 8'd0;
			tx.crc_ok   = rec_s1.ok;
			tx.last_out = 1'b1;
		end else begin
			case (idx_q)
				2'd0: begin
					kind        = crc8hx_pkg::KIND_ECHO;
					tx.char_out = rec_s1.ch;
				end
				2'd1: begin
					kind        = crc8hx_pkg::KIND_HEX;
					tx.char_out = crc8hx_pkg::nibble_to_hex(
						4'((rec_s1.crc & crc8hx_pkg::NIB_HI_MASK) >> 4));
				end
				2'd2: begin
					kind        = crc8hx_pkg::KIND_HEX;
					tx.char_out = crc8hx_pkg::nibble_to_hex(
						4'(rec_s1.crc & crc8hx_pkg::NIB_LO_MASK));
					tx.last_out = 1'b1;
				end
				default: begin
					kind        = crc8hx_pkg::KIND_ECHO;
					tx.char_out = rec_s1.ch;
				end
			endcase
		end
	end

	assign tx.kind  = kind;
	assign tx.valid = vld_s1;

	always_ff @(posedge clk) begin
		if (rec_load) begin
			rec_s1 <= rec_i;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			idx_q  <= 2'd0;
		end else if (rec_load) begin
			vld_s1 <= 1'b1;
			idx_q  <= 2'd0;
		end else if (vld_s1 && tx.ready) begin
			if (beat_last) begin
				vld_s1 <= 1'b0;
				idx_q  <= 2'd0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	a_verdict_single: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && rec_s1.check) |-> (idx_q == 2'd0))
		else $error("verdict beat past index zero");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && tx.ready && beat_last && !rec_load) |=> !vld_s1)
		else $error("result stage did not drain");

	a_hex_step: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !tx.ready) |=> (vld_s1 && $stable(idx_q)))
		else $error("beat index moved under stall");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q != 2'd3)
		else $error("beat index out of range");

endmodule

// ===== rtl/crc8_hex_append_and_check.sv =====
// CRC-8 (reflected poly 0x8C, init 0) over a character stream, one character per beat.
// mode 0 echoes every character and, after the one flagged last, appends the CRC as two
// uppercase hex characters (high nibble first, last_out on the low one). mode 1 holds back
// the final two characters, and at the last beat emits a single verdict beat comparing them,
// hex-decoded, with the CRC of everything before; fewer than two characters fails. A mode
// write clears any message in progress. Throughput is one character per clock while tx.ready
// is high, except for the last character in generate mode, which occupies the single result
// register for three output beats. In check mode ordinary characters produce no output and
// flow at one per clock unless a verdict waits; output appears the cycle after acceptance.
module crc8_hex_append_and_check (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic          cfg_wdata,
	crc8hx_in_if.sink     rx,
	crc8hx_out_if.source  tx
);

	crc8hx_pkg::rec_t rec;
	logic             rec_load;
	logic             slot_free;
	logic             accept;

	assign rx.ready = slot_free;
	assign accept   = rx.valid && slot_free;

	crc8hx_msg u_msg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.accept    (accept),
		.char_in   (rx.char_in),
		.last_char (rx.last_char),
		.rec       (rec),
		.rec_load  (rec_load)
	);

	crc8hx_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec_i     (rec),
		.rec_load  (rec_load),
		.slot_free (slot_free),
		.tx        (tx)
	);

endmodule

// ===== tb/crc8_hex_append_and_check_checker.sv =====
module crc8_hex_append_and_check_checker
	import crc8hx_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   cfg_we,
	input  logic   cfg_wdata,
	crc8hx_in_if   rx,
	crc8hx_out_if  tx,
	output int     errors,
	output int     pending,
	output int     beats_done,
	output int     verdicts_ok
);

	typedef struct packed {
		kind_t      kind;
		logic [7:0] ch;
		logic       ok;
		logic       last;
	} out_beat_t;

	out_beat_t  expected_beats[$];
	out_beat_t  want;

	logic [0:0] mode_q;
	logic [7:0] run_crc;
	logic [7:0] hold_old;
	logic [7:0] hold_new;
	logic [1:0] held_n;

	// Bit-serial form, data LSB first.
	function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] d);
		logic [7:0] r;
		logic       fb;
		r = crc;
		for (int i = 0; i < 8; i++) begin
			fb = r[0] ^ d[i];
			r = {1'b0, r[7:1]} ^ (fb ? CRC_POLY : 8'h00);
		end
		return r;
	endfunction

	function automatic logic [7:0] ascii_of_nib(input logic [3:0] n);
		return (n < 4'd10) ? (ASCII_ZERO + n) : (ASCII_A_OFS + n);
	endfunction

	function automatic logic [3:0] nib_of_ascii(input logic [7:0] c);
		logic [7:0] v;
		v = 8'd0;
		if (c >= ASCII_ZERO && c <= ASCII_NINE) begin
			v = c - ASCII_ZERO;
		end else if (c >= ASCII_UPPER_A && c <= ASCII_UPPER_F) begin
			v = c - ASCII_A_OFS;
		end
		return v[3:0];
	endfunction

	function automatic out_beat_t mk_beat(input kind_t k, input logic [7:0] c, input logic ok,
			input logic l);
		out_beat_t b;
		b.kind = k;
		b.ch = c;
		b.ok = ok;
		b.last = l;
		return b;
	endfunction

	task automatic clear_msg();
		run_crc = 8'd0;
		hold_old = 8'd0;
		hold_new = 8'd0;
		held_n = 2'd0;
	endtask

	task automatic predict_beat(input logic [7:0] c, input logic l);
		logic ok;
		ok = 1'b0;
		if (mode_q == MODE_GEN) begin
			run_crc = crc_fold(run_crc, c);
			expected_beats.push_back(mk_beat(KIND_ECHO, c, 1'b0, 1'b0));
			if (l) begin
				expected_beats.push_back(mk_beat(KIND_HEX, ascii_of_nib(run_crc[7:4]), 1'b0, 1'b0));
				expected_beats.push_back(mk_beat(KIND_HEX, ascii_of_nib(run_crc[3:0]), 1'b0, 1'b1));
				clear_msg();
			end
		end else if (!l) begin
			// two newest chars stay held back; only older ones go into the CRC
			if (held_n == SEEN_FULL) begin
				run_crc = crc_fold(run_crc, hold_old);
			end
			hold_old = hold_new;
			hold_new = c;
			if (held_n != SEEN_FULL) begin
				held_n = held_n + 2'd1;
			end
		end else begin
			if (held_n != 2'd0) begin
				if (held_n == SEEN_FULL) begin
					run_crc = crc_fold(run_crc, hold_old);
				end
				ok = ({nib_of_ascii(hold_new), nib_of_ascii(c)} == run_crc);
			end
			expected_beats.push_back(mk_beat(KIND_VERDICT, 8'd0, ok, 1'b1));
			clear_msg();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q = MODE_GEN;
			clear_msg();
			expected_beats.delete();
			pending = 0;
			errors = 0;
			beats_done = 0;
			verdicts_ok = 0;
		end else begin
			if (cfg_we) begin
				mode_q = cfg_wdata;
				clear_msg();
			end
			if (rx.valid && rx.ready) begin
				predict_beat(rx.char_in, rx.last_char);
			end
			if (tx.valid && tx.ready) begin
				beats_done++;
				if (expected_beats.size() == 0) begin
					$error("unexpected output beat: kind %0d char_out %02h crc_ok %0d last_out %0d",
						tx.kind, tx.char_out, tx.crc_ok, tx.last_out);
					errors++;
				end else begin
					want = expected_beats.pop_front();
					if (tx.kind !== want.kind) begin
						$error("kind: expected %0d, actual %0d", want.kind, tx.kind);
						errors++;
					end
					if (tx.char_out !== want.ch) begin
						$error("char_out: expected %02h, actual %02h", want.ch, tx.char_out);
						errors++;
					end
					if (tx.crc_ok !== want.ok) begin
						$error("crc_ok: expected %0d, actual %0d", want.ok, tx.crc_ok);
						errors++;
					end
					if (tx.last_out !== want.last) begin
						$error("last_out: expected %0d, actual %0d", want.last, tx.last_out);
						errors++;
					end
					if (want.kind == KIND_VERDICT && want.ok && tx.crc_ok === 1'b1) begin
						verdicts_ok++;
					end
				end
			end
			pending = expected_beats.size();
		end
	end

endmodule

// ===== tb/crc8_hex_append_and_check_tb.sv =====
module crc8_hex_append_and_check_tb;
	import crc8hx_pkg::*;

	localparam int CYCLE_LIMIT = 100000;
	localparam int HOLD_CYCLES = 80;
	localparam int RAND_ITEMS  = 200;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	crc8hx_in_if  in_ch ();
	crc8hx_out_if out_ch ();

	int errors;
	int pending;
	int beats_done;
	int verdicts_ok;

	int cycles = 0;
	int items_sent = 0;
	int messages = 0;
	int mode_writes = 0;
	int hold_asked = 0;
	bit idle_on = 1'b1;

	logic [7:0] msg_buf[$];

	crc8_hex_append_and_check uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.rx        (in_ch),
		.tx        (out_ch)
	);

	crc8_hex_append_and_check_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.rx          (in_ch),
		.tx          (out_ch),
		.errors      (errors),
		.pending     (pending),
		.beats_done  (beats_done),
		.verdicts_ok (verdicts_ok)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Receiver: random back-pressure, plus a long hold-off on request.
	initial begin
		int hold_left;
		int hold_taken;
		hold_left = 0;
		hold_taken = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_ch.ready <= 1'b0;
				hold_left--;
			end else if (hold_taken != hold_asked) begin
				out_ch.ready <= 1'b0;
				hold_left = HOLD_CYCLES;
				hold_taken = hold_asked;
			end else begin
				out_ch.ready <= !(idle_on && $urandom_range(99) < 22);
			end
		end
	end

	// Stimulus-side CRC, used only to build well-formed check messages.
	function automatic logic [7:0] step_crc(input logic [7:0] crc, input logic [7:0] d);
		logic [7:0] r;
		r = crc ^ d;
		repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		return r;
	endfunction

	function automatic logic [7:0] hex_digit(input logic [3:0] n);
		return (n < 4'd10) ? (ASCII_ZERO + n) : (ASCII_A_OFS + n);
	endfunction

	task automatic push_char(input logic [7:0] c, input logic l);
		while (idle_on && $urandom_range(99) < 22) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.char_in <= c;
		in_ch.last_char <= l;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_msg(input bit close);
		int i;
		for (i = 0; i < msg_buf.size(); i++) begin
			push_char(msg_buf[i], close && (i == msg_buf.size() - 1));
		end
		if (close) begin
			messages++;
		end
	endtask

	task automatic fill_random(input int len);
		msg_buf.delete();
		repeat (len) msg_buf.push_back(8'($urandom_range(255)));
	endtask

	// Append the CRC of msg_buf as two hex chars, optionally damaged.
	task automatic append_crc(input bit mangle);
		logic [7:0] crc;
		logic [7:0] hi;
		logic [7:0] lo;
		int i;
		crc = 8'd0;
		for (i = 0; i < msg_buf.size(); i++) begin
			crc = step_crc(crc, msg_buf[i]);
		end
		hi = hex_digit(crc[7:4]);
		lo = hex_digit(crc[3:0]);
		if (mangle) begin
			case ($urandom_range(2))
				0: begin
					hi = hi | 8'h20; // lowercase letter no longer decodes
				end
				1: begin
					lo = 8'($urandom_range(255));
				end
				default: begin
					hi = hi ^ 8'h01;
				end
			endcase
		end
		msg_buf.push_back(hi);
		msg_buf.push_back(lo);
	endtask

	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_mode(input logic [0:0] m);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(negedge clk);
		cfg_we <= 1'b0;
		mode_writes++;
	endtask

	initial begin
		int rand_goal;
		int phase;
		logic [0:0] cur_mode;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.char_in = 8'd0;
		in_ch.last_char = 1'b0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// generate mode out of reset: extremes and a zero byte mid-message
		msg_buf = '{8'h00};
		send_msg(1'b1);
		msg_buf = '{8'hFF};
		send_msg(1'b1);
		msg_buf = '{8'h31, 8'h00, 8'h7A, 8'h80};
		send_msg(1'b1);

		write_mode(MODE_CHECK);
		msg_buf = '{8'h41};                      // too short: fails
		send_msg(1'b1);
		msg_buf = '{ASCII_ZERO, ASCII_ZERO};     // empty body, "00" matches zero CRC
		send_msg(1'b1);
		msg_buf = '{8'h00, 8'hFF};
		append_crc(1'b0);
		send_msg(1'b1);
		msg_buf = '{8'h12, 8'h47, 8'h7A};        // non-hex pair decodes as 0
		send_msg(1'b1);
		// message in progress dropped by a mode write
		msg_buf = '{8'h55, 8'h66, 8'h77};
		send_msg(1'b0);
		write_mode(MODE_CHECK);
		msg_buf = '{8'h41};
		append_crc(1'b0);
		send_msg(1'b1);

		write_mode(MODE_GEN);
		msg_buf = '{8'hAA, 8'hBB};
		send_msg(1'b0);
		write_mode(MODE_GEN);
		msg_buf = '{8'h10};
		send_msg(1'b1);

		rand_goal = items_sent + RAND_ITEMS;
		phase = 0;
		while (items_sent < rand_goal) begin
			cur_mode = phase[0] ? MODE_CHECK : MODE_GEN;
			write_mode(cur_mode);
			idle_on = (phase != 3);
			if (phase == 2) begin
				// receiver stalls while a long message keeps coming
				hold_asked++;
				fill_random(12);
				send_msg(1'b1);
			end
			repeat ($urandom_range(2, 5)) begin
				if (cur_mode == MODE_GEN) begin
					fill_random($urandom_range(1, 8));
				end else if ($urandom_range(99) < 70) begin
					fill_random($urandom_range(0, 6));
					append_crc($urandom_range(99) < 15);
				end else begin
					fill_random($urandom_range(1, 6));
				end
				send_msg(1'b1);
			end
			if ($urandom_range(3) == 0) begin
				fill_random($urandom_range(1, 4));
				send_msg(1'b0);
			end
			phase++;
		end
		idle_on = 1'b1;

		wait_drained();
		repeat (8) @(negedge clk);
		$display("Run covered %0d input beats in %0d complete messages across %0d mode writes.",
			items_sent, messages, mode_writes);
		$display("%0d output beats checked, %0d check verdicts passed.", beats_done, verdicts_ok);
		if (errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/crc8hx_pkg.sv
rtl/crc8hx_if.sv
rtl/crc8hx_msg.sv
rtl/crc8hx_out.sv
rtl/crc8_hex_append_and_check.sv
tb/crc8_hex_append_and_check_checker.sv
tb/crc8_hex_append_and_check_tb.sv
